/* rtl/mau_pkg.sv */
// Shared types, codes and constants of the modular arithmetic unit.
`default_nettype none
package mau_pkg;

    localparam int unsigned MOD_W  = 63;
    localparam int unsigned WORD_W = 64;
    localparam int unsigned FUNC_W = 3;

    localparam logic [MOD_W-1:0] MODULUS_RESET = 63'd1000000007;

    localparam logic [FUNC_W-1:0] FN_ADD = 3'd0;
    localparam logic [FUNC_W-1:0] FN_SUB = 3'd1;
    localparam logic [FUNC_W-1:0] FN_MUL = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DIV = 3'd3;
    localparam logic [FUNC_W-1:0] FN_POW = 3'd4;
    localparam logic [FUNC_W-1:0] FN_INV = 3'd5;

    typedef enum logic [1:0] {
        MODE_DIV,
        MODE_MUL,
        MODE_ADD,
        MODE_SUB
    } alu_mode_t;

    typedef struct packed {
        alu_mode_t        mode;
        logic [MOD_W-1:0] div;
    } alu_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_A,
        ST_RED_B,
        ST_DISPATCH,
        ST_MUL,
        ST_POW_STEP,
        ST_POW_SQ,
        ST_POW_ML,
        ST_EUC_TEST,
        ST_EUC_DIV,
        ST_EUC_MUL,
        ST_EUC_SUB,
        ST_QMUL,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

/* rtl/mau_alu.sv */
// Shared step unit: one divide bit, one multiply bit, modular add or subtract.
`default_nettype none
module mau_alu (
    input  var mau_pkg::alu_ctrl_t              ctrl,
    input  wire logic [mau_pkg::MOD_W-1:0]      p,
    input  wire logic [mau_pkg::MOD_W-1:0]      q,
    input  wire logic [mau_pkg::WORD_W-1:0]     w,
    output logic      [mau_pkg::MOD_W-1:0]      r,
    output logic      [mau_pkg::WORD_W-1:0]     w_out
);
    import mau_pkg::*;

    logic [WORD_W-1:0] dw;
    logic [WORD_W-1:0] shl;
    logic              ge;
    logic [WORD_W-1:0] dbl;
    logic [MOD_W-1:0]  dbl_red;
    logic [WORD_W-1:0] sum;
    logic [MOD_W-1:0]  sum_red;
    logic [WORD_W-1:0] add_s;
    logic [WORD_W-1:0] sub_s;

    always_comb begin
        dw  = {1'b0, ctrl.div};
        shl = {p, w[WORD_W-1]};
        ge  = (shl >= dw);
        // double then conditionally add the multiplicand
        dbl     = {p, 1'b0};
        dbl_red = (dbl >= dw) ? MOD_W'(dbl - dw) : dbl[MOD_W-1:0];
        sum     = {1'b0, dbl_red} + {1'b0, q};
        sum_red = (sum >= dw) ? MOD_W'(sum - dw) : sum[MOD_W-1:0];
        add_s   = {1'b0, p} + {1'b0, q};
        sub_s   = {1'b0, p} + dw - {1'b0, q};
        r     = '0;
        w_out = w;
        unique case (ctrl.mode)
            MODE_DIV: begin
                r     = ge ? MOD_W'(shl - dw) : shl[MOD_W-1:0];
                w_out = {w[WORD_W-2:0], ge};
            end
            MODE_MUL: begin
                r     = w[WORD_W-1] ? sum_red : dbl_red;
                w_out = {w[WORD_W-2:0], 1'b0};
            end
            MODE_ADD: begin
                r = (add_s >= dw) ? MOD_W'(add_s - dw) : add_s[MOD_W-1:0];
            end
            MODE_SUB: begin
                r = (p >= q) ? MOD_W'(p - q) : sub_s[MOD_W-1:0];
            end
            default: r = '0;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/modular_arithmetic_unit.sv */
// Top level: modular arithmetic sequencer around one shared step unit.
// Usage:
//   Input words arrive on s_tvalid/s_tready: s_tuser is the operation
//   (add, sub, mul, div, pow, inv), s_tdata holds both 64-bit operands.
//   One result word per input leaves on m_tvalid/m_tready: m_tdata holds
//   the result, m_tuser the error flag (no inverse; result then 0).
//   cfg_we/cfg_wdata write the modulus; write it only while idle.
// Sequence, one step of the shared unit per cycle:
//   reduction of both operands; then add/sub at dispatch, mul by
//   shift and add, pow by a squaring per exponent bit plus a multiply
//   for each set bit, div/inv by Euclid iterations (divide, multiply,
//   subtract), plus a final product for div. A zero modulus or an
//   unused code skips all steps. s_tready is high only between words.
// Reset sets the modulus to 1000000007 and empties the output register.
// A stalled receiver holds the finished word in the output register; the
// next input word is taken and worked on meanwhile, and waits at its end.
`default_nettype none
module modular_arithmetic_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [mau_pkg::MOD_W-1:0]      cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [127:0]                   s_tdata,  // operand_a, operand_b
    input  wire logic [mau_pkg::FUNC_W-1:0]     s_tuser,  // func
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [63:0]                    m_tdata,  // result, zero pad
    output logic                                m_tuser   // error
);
    import mau_pkg::*;

    state_t              state_reg, state_next;
    logic [MOD_W-1:0]    mod_reg, mod_next;
    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [WORD_W-1:0]   w_reg, w_next;
    logic [WORD_W-1:0]   e_reg, e_next;
    logic [MOD_W-1:0]    acc_reg, acc_next;
    logic [MOD_W-1:0]    x_reg, x_next;
    logic [MOD_W-1:0]    a_reg, a_next;
    logic [MOD_W-1:0]    b_reg, b_next;
    logic [MOD_W-1:0]    pacc_reg, pacc_next;
    logic [MOD_W-1:0]    ea_reg, ea_next;
    logic [MOD_W-1:0]    eb_reg, eb_next;
    logic [MOD_W-1:0]    ca_reg, ca_next;
    logic [MOD_W-1:0]    cb_reg, cb_next;
    logic [MOD_W-1:0]    rm_reg, rm_next;
    logic [MOD_W-1:0]    res_reg, res_next;
    logic                err_reg, err_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [6:0]          ecnt_reg, ecnt_next;
    logic [MOD_W-1:0]    out_res_reg, out_res_next;
    logic                out_err_reg, out_err_next;
    logic                m_valid_reg, m_valid_next;

    alu_ctrl_t           alu_ctrl;
    logic [MOD_W-1:0]    alu_p, alu_q, alu_r;
    logic [WORD_W-1:0]   alu_w_out;
    logic                last_step;
    logic [MOD_W-1:0]    one_mod;

    mau_alu u_alu (
        .ctrl  (alu_ctrl),
        .p     (alu_p),
        .q     (alu_q),
        .w     (w_reg),
        .r     (alu_r),
        .w_out (alu_w_out)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {1'b0, out_res_reg};
    assign m_tuser   = out_err_reg;
    assign last_step = (cnt_reg == 6'd63);
    assign one_mod   = (mod_reg == MOD_W'(1)) ? '0 : MOD_W'(1);

    // operand selection for the shared unit
    always_comb begin
        alu_ctrl.mode = MODE_MUL;
        alu_ctrl.div  = mod_reg;
        alu_p         = acc_reg;
        alu_q         = x_reg;
        unique case (state_reg)
            ST_RED_A, ST_RED_B: alu_ctrl.mode = MODE_DIV;
            ST_EUC_DIV: begin
                alu_ctrl.mode = MODE_DIV;
                alu_ctrl.div  = eb_reg;
            end
            ST_DISPATCH: begin
                alu_ctrl.mode = (func_reg == FN_SUB) ? MODE_SUB : MODE_ADD;
                alu_p         = a_reg;
                alu_q         = b_reg;
            end
            ST_EUC_SUB: begin
                alu_ctrl.mode = MODE_SUB;
                alu_p         = ca_reg;
                alu_q         = acc_reg;
            end
            default: alu_ctrl.mode = MODE_MUL;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        mod_next     = cfg_we ? cfg_wdata : mod_reg;
        func_next    = func_reg;
        w_next       = w_reg;
        e_next       = e_reg;
        acc_next     = acc_reg;
        x_next       = x_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        pacc_next    = pacc_reg;
        ea_next      = ea_reg;
        eb_next      = eb_reg;
        ca_next      = ca_reg;
        cb_next      = cb_reg;
        rm_next      = rm_reg;
        res_next     = res_reg;
        err_next     = err_reg;
        cnt_next     = 6'd0;
        ecnt_next    = ecnt_reg;
        out_res_next = out_res_reg;
        out_err_next = out_err_reg;
        m_valid_next = m_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next = s_tuser;
                    w_next    = s_tdata[63:0];
                    e_next    = s_tdata[127:64];
                    acc_next  = '0;
                    res_next  = '0;
                    err_next  = 1'b0;
                    if (mod_reg == '0 || s_tuser > FN_INV) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_RED_A;
                    end
                end
            end
            ST_RED_A: begin
                acc_next = alu_r;
                w_next   = alu_w_out;
                cnt_next = cnt_reg + 6'd1;
                if (last_step) begin
                    a_next     = alu_r;
                    acc_next   = '0;
                    w_next     = e_reg;
                    state_next = ST_RED_B;
                end
            end
            ST_RED_B: begin
                acc_next = alu_r;
                w_next   = alu_w_out;
                cnt_next = cnt_reg + 6'd1;
                if (last_step) begin
                    b_next     = alu_r;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                acc_next = '0;
                ca_next  = one_mod;
                cb_next  = '0;
                eb_next  = mod_reg;
                unique case (func_reg)
                    FN_ADD, FN_SUB: begin
                        res_next   = alu_r;
                        state_next = ST_DONE;
                    end
                    FN_MUL: begin
                        x_next     = a_reg;
                        w_next     = {1'b0, b_reg};
                        state_next = ST_MUL;
                    end
                    FN_POW: begin
                        pacc_next  = one_mod;
                        ecnt_next  = '0;
                        state_next = ST_POW_STEP;
                    end
                    FN_DIV: begin
                        ea_next    = b_reg;
                        state_next = ST_EUC_TEST;
                    end
                    FN_INV: begin
                        ea_next    = a_reg;
                        state_next = ST_EUC_TEST;
                    end
                    default: state_next = ST_DONE;
                endcase
            end
            ST_MUL: begin
                acc_next = alu_r;
                w_next   = alu_w_out;
                cnt_next = cnt_reg + 6'd1;
                if (last_step) begin
                    res_next   = alu_r;
                    state_next = ST_DONE;
                end
            end
            ST_POW_STEP: begin
                if (ecnt_reg == 7'(WORD_W)) begin
                    res_next   = pacc_reg;
                    state_next = ST_DONE;
                end else begin
                    acc_next   = '0;
                    x_next     = pacc_reg;
                    w_next     = {1'b0, pacc_reg};
                    state_next = ST_POW_SQ;
                end
            end
            ST_POW_SQ: begin
                acc_next = alu_r;
                w_next   = alu_w_out;
                cnt_next = cnt_reg + 6'd1;
                if (last_step) begin
                    pacc_next = alu_r;
                    if (e_reg[WORD_W-1]) begin
                        acc_next   = '0;
                        x_next     = alu_r;
                        w_next     = {1'b0, a_reg};
                        state_next = ST_POW_ML;
                    end else begin
                        e_next     = {e_reg[WORD_W-2:0], 1'b0};
                        ecnt_next  = ecnt_reg + 7'd1;
                        state_next = ST_POW_STEP;
                    end
                end
            end
            ST_POW_ML: begin
                acc_next = alu_r;
                w_next   = alu_w_out;
                cnt_next = cnt_reg + 6'd1;
                if (last_step) begin
                    pacc_next  = alu_r;
                    e_next     = {e_reg[WORD_W-2:0], 1'b0};
                    ecnt_next  = ecnt_reg + 7'd1;
                    state_next = ST_POW_STEP;
                end
            end
            ST_EUC_TEST: begin
                acc_next = '0;
                if (eb_reg == '0) begin
                    if (ea_reg != MOD_W'(1)) begin
                        res_next   = '0;
                        err_next   = 1'b1;
                        state_next = ST_DONE;
                    end else if (func_reg == FN_INV) begin
                        res_next   = ca_reg;
                        state_next = ST_DONE;
                    end else begin
                        x_next     = a_reg;
                        w_next     = {1'b0, ca_reg};
                        state_next = ST_QMUL;
                    end
                end else begin
                    w_next     = {1'b0, ea_reg};
                    state_next = ST_EUC_DIV;
                end
            end
            ST_EUC_DIV: begin
                acc_next = alu_r;
                w_next   = alu_w_out;
                cnt_next = cnt_reg + 6'd1;
                if (last_step) begin
                    // remainder kept aside; quotient stays in w as multiplier
                    rm_next    = alu_r;
                    acc_next   = '0;
                    x_next     = cb_reg;
                    state_next = ST_EUC_MUL;
                end
            end
            ST_EUC_MUL: begin
                acc_next = alu_r;
                w_next   = alu_w_out;
                cnt_next = cnt_reg + 6'd1;
                if (last_step) begin
                    state_next = ST_EUC_SUB;
                end
            end
            ST_EUC_SUB: begin
                ea_next    = eb_reg;
                eb_next    = rm_reg;
                ca_next    = cb_reg;
                cb_next    = alu_r;
                state_next = ST_EUC_TEST;
            end
            ST_QMUL: begin
                acc_next = alu_r;
                w_next   = alu_w_out;
                cnt_next = cnt_reg + 6'd1;
                if (last_step) begin
                    res_next   = alu_r;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    out_res_next = res_reg;
                    out_err_next = err_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mod_reg     <= MODULUS_RESET;
            m_valid_reg <= 1'b0;
            cnt_reg     <= 6'd0;
        end else begin
            state_reg   <= state_next;
            mod_reg     <= mod_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        w_reg       <= w_next;
        e_reg       <= e_next;
        acc_reg     <= acc_next;
        x_reg       <= x_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        pacc_reg    <= pacc_next;
        ea_reg      <= ea_next;
        eb_reg      <= eb_next;
        ca_reg      <= ca_next;
        cb_reg      <= cb_next;
        rm_reg      <= rm_next;
        res_reg     <= res_next;
        err_reg     <= err_next;
        ecnt_reg    <= ecnt_next;
        out_res_reg <= out_res_next;
        out_err_reg <= out_err_next;
    end

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice in a row");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("error word with nonzero result");

    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_valid_reg || m_tready)) |=> m_valid_reg)
        else $error("finished word not loaded");

    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && mod_reg != '0) |-> (out_res_reg < mod_reg))
        else $error("result not below modulus");
`endif

endmodule
`default_nettype wire

/* tb/sv/modular_arithmetic_unit_test.sv */
// Self-checking testbench of the modular arithmetic unit: directed table, then random words.
`timescale 1ns / 100ps

module modular_arithmetic_unit_test;
    import mau_pkg::*;

    localparam logic [FUNC_W-1:0] FN_RSVD_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FN_RSVD_HI = 3'd7;
    localparam longint unsigned   CYCLE_LIMIT = 64'd60_000_000;
    localparam logic [63:0]       ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0]       P_RESET = 64'd1000000007;

    typedef struct {
        logic [MOD_W-1:0] result;
        logic             error;
    } mod_result_t;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [63:0]       a;
        logic [63:0]       b;
        bit                typed;
        logic [MOD_W-1:0]  result;
        logic              error;
    } vector_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_we;
    logic [MOD_W-1:0]    cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [127:0]        s_tdata;   // operand_a, operand_b
    logic [FUNC_W-1:0]   s_tuser;   // func
    logic                m_tvalid;
    logic                m_tready;
    logic [63:0]         m_tdata;   // result, zero pad
    logic                m_tuser;   // error

    logic [63:0]         cur_modulus;
    mod_result_t         pending_q[$];
    int unsigned         fail_count;
    int unsigned         words_in;
    int unsigned         words_out;
    int unsigned         err_words;
    bit                  no_idle;
    int unsigned         ready_hold;
    longint unsigned     cycle_count;

    modular_arithmetic_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #6 aclk = ~aclk;

    function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
        logic [127:0] prod;
        prod = {64'd0, x} * {64'd0, y};
        return 64'(prod % {64'd0, m});
    endfunction

    function automatic logic [63:0] pow_mod(logic [63:0] x, logic [63:0] e, logic [63:0] m);
        logic [63:0] acc;
        acc = 64'd1 % m;
        for (int i = 63; i >= 0; i--) begin
            acc = mul_mod(acc, acc, m);
            if (e[i])
                acc = mul_mod(acc, x, m);
        end
        return acc;
    endfunction

    // Extended Euclid; coprime cleared when gcd(x, m) is not one.
    function automatic logic [63:0] inv_mod(logic [63:0] x, logic [63:0] m, output bit coprime);
        logic [63:0] ra, rb, ca, cb, q, r, t, p;
        ra = x;
        rb = m;
        ca = 64'd1 % m;
        cb = 64'd0;
        while (rb != 0) begin
            q = ra / rb;
            r = ra % rb;
            p = mul_mod(cb, q % m, m);
            t = (ca >= p) ? ca - p : ca + m - p;
            ra = rb;
            rb = r;
            ca = cb;
            cb = t;
        end
        coprime = (ra == 64'd1);
        return coprime ? ca : 64'd0;
    endfunction

    function automatic mod_result_t predict_mod(logic [FUNC_W-1:0] func, logic [63:0] op_a,
                                                logic [63:0] op_b);
        mod_result_t res;
        logic [63:0] m, a, b, v, s;
        bit coprime;
        m = cur_modulus;
        res.result = '0;
        res.error = 1'b0;
        coprime = 1'b1;
        v = 64'd0;
        if (m != 0) begin
            a = op_a % m;
            b = op_b % m;
            case (func)
                FN_ADD: begin
                    s = a + b;
                    v = (s >= m) ? s - m : s;
                end
                FN_SUB: v = (a >= b) ? a - b : a + m - b;
                FN_MUL: v = mul_mod(a, b, m);
                FN_DIV: begin
                    v = inv_mod(b, m, coprime);
                    v = coprime ? mul_mod(a, v, m) : 64'd0;
                end
                FN_POW: v = pow_mod(a, op_b, m);
                FN_INV: v = inv_mod(a, m, coprime);
                default: v = 64'd0;
            endcase
            if (!coprime) begin
                v = 64'd0;
                res.error = 1'b1;
            end
        end
        res.result = v[MOD_W-1:0];
        return res;
    endfunction

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, 4);
    endfunction

    task automatic send_word(logic [FUNC_W-1:0] func, logic [63:0] a, logic [63:0] b,
                             mod_result_t expected);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_q.push_back(expected);
        words_in++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_modulus(logic [MOD_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_modulus = {1'b0, value};
    endtask

    function automatic logic [63:0] draw_operand();
        case ($urandom_range(0, 7))
            0: return 64'($urandom_range(0, 15));
            1: return cur_modulus - 1;
            2: return cur_modulus;
            3: return ALL_ONES;
            4: return 64'($urandom);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_words(int unsigned count);
        logic [FUNC_W-1:0] fn_list[6];
        logic [FUNC_W-1:0] func;
        logic [63:0] a, b;
        fn_list = '{FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_POW, FN_INV};
        for (int unsigned n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 3)
                func = $urandom_range(0, 1) ? FN_RSVD_HI : FN_RSVD_LO;
            else
                func = fn_list[$urandom_range(0, 5)];
            a = draw_operand();
            b = draw_operand();
            // Keep exponents short; only a few walk all 64 bits.
            if (func == FN_POW && $urandom_range(0, 39) != 0)
                b = 64'($urandom_range(0, 255));
            send_word(func, a, b, predict_mod(func, a, b));
        end
    endtask

    // Result side: check each word, then hold ready low for a drawn gap, if any.
    always @(posedge aclk) begin
        mod_result_t want;
        int unsigned w;
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            if (ready_hold == 1)
                m_tready <= 1'b1;
        end else if (aresetn && m_tvalid && m_tready) begin
            words_out++;
            if (m_tuser)
                err_words++;
            if (pending_q.size() == 0) begin
                $error("result word with nothing pending: result %0d error %0b",
                       m_tdata[MOD_W-1:0], m_tuser);
                fail_count++;
            end else begin
                want = pending_q.pop_front();
                if (m_tdata[MOD_W-1:0] !== want.result) begin
                    $error("result: expected %0d, got %0d", want.result, m_tdata[MOD_W-1:0]);
                    fail_count++;
                end
                if (m_tuser !== want.error) begin
                    $error("error: expected %0b, got %0b", want.error, m_tuser);
                    fail_count++;
                end
            end
            w = draw_gap();
            if (w != 0) begin
                m_tready <= 1'b0;
                ready_hold <= w;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words pending", cycle_count,
                     pending_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        vector_t     vectors[$];
        mod_result_t expected;
        logic [63:0] big_mod;

        fail_count = 0;
        words_in = 0;
        words_out = 0;
        err_words = 0;
        no_idle = 1'b0;
        ready_hold = 0;
        cycle_count = 0;
        cur_modulus = P_RESET;
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= FN_ADD;
        m_tready <= 1'b1;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset modulus 1e9+7; typed rows carry their answer, the rest go to the predictor.
        vectors = '{
            '{FN_ADD, 64'd0, 64'd0, 1, 63'd0, 1'b0},
            '{FN_ADD, P_RESET - 1, 64'd1, 1, 63'd0, 1'b0},
            '{FN_ADD, ALL_ONES, ALL_ONES, 0, 63'd0, 1'b0},
            '{FN_SUB, 64'd0, 64'd1, 1, 63'd1000000006, 1'b0},
            '{FN_SUB, ALL_ONES, 64'd0, 0, 63'd0, 1'b0},
            '{FN_MUL, P_RESET - 1, P_RESET - 1, 1, 63'd1, 1'b0},
            '{FN_MUL, ALL_ONES, ALL_ONES, 0, 63'd0, 1'b0},
            '{FN_DIV, 64'd5, 64'd0, 1, 63'd0, 1'b1},
            '{FN_DIV, 64'd6, 64'd3, 1, 63'd2, 1'b0},
            '{FN_DIV, 64'd9, P_RESET, 1, 63'd0, 1'b1},
            '{FN_DIV, ALL_ONES, ALL_ONES, 0, 63'd0, 1'b0},
            '{FN_POW, 64'd7, 64'd0, 1, 63'd1, 1'b0},
            '{FN_POW, 64'd0, 64'd0, 1, 63'd1, 1'b0},
            '{FN_POW, 64'd2, 64'd10, 1, 63'd1024, 1'b0},
            '{FN_POW, ALL_ONES, ALL_ONES, 0, 63'd0, 1'b0},
            '{FN_INV, 64'd0, ALL_ONES, 1, 63'd0, 1'b1},
            '{FN_INV, 64'd1, 64'd0, 1, 63'd1, 1'b0},
            '{FN_INV, P_RESET - 1, 64'd0, 1, 63'd1000000006, 1'b0},
            '{FN_INV, ALL_ONES, 64'd0, 0, 63'd0, 1'b0},
            '{FN_RSVD_LO, 64'd3, 64'd4, 1, 63'd0, 1'b0},
            '{FN_RSVD_HI, ALL_ONES, ALL_ONES, 1, 63'd0, 1'b0}
        };
        foreach (vectors[i]) begin
            if (vectors[i].typed) begin
                expected.result = vectors[i].result;
                expected.error = vectors[i].error;
            end else begin
                expected = predict_mod(vectors[i].func, vectors[i].a, vectors[i].b);
            end
            send_word(vectors[i].func, vectors[i].a, vectors[i].b, expected);
        end
        random_words(120);
        no_idle = 1'b1;
        random_words(80);
        no_idle = 1'b0;
        random_words(50);
        drain();

        write_modulus(63'd2);
        random_words(80);
        drain();
        write_modulus({MOD_W{1'b1}});
        random_words(50);
        drain();
        big_mod = {1'b0, 1'b1, 30'($urandom), $urandom} | 64'd1;
        write_modulus(big_mod[MOD_W-1:0]);
        random_words(50);
        drain();
        write_modulus(63'd97);
        no_idle = 1'b1;
        random_words(70);
        no_idle = 1'b0;
        random_words(80);
        drain();
        write_modulus(63'd1);
        random_words(40);
        drain();
        write_modulus(63'd0);
        random_words(40);
        drain();
        write_modulus(63'($urandom_range(3, 1 << 20)) | 63'd1);
        random_words(150);
        drain();
        write_modulus(MODULUS_RESET);
        random_words(20);
        drain();

        $display("%0d words sent, %0d results checked (%0d with error set)",
                 words_in, words_out, err_words);
        $display("moduli covered: 1e9+7, 2, 2^63-1, random wide, 97, 1, 0, random small");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
